@@ sv/texture_half_downsampler_assert.svh @@
// Assertion macros for the texture half downsampler.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TEXTURE_HALF_DOWNSAMPLER_ASSERT_SVH
`define TEXTURE_HALF_DOWNSAMPLER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define THD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("thd assertion failed: lbl");
// Next-cycle implication, disabled while reset is asserted.
`define THD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("thd assertion failed: lbl");
`else
`define THD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define THD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/thd_pkg.sv @@
// Shared constants for the texture half downsampler.
// No dependencies; imported by texture_half_downsampler.
`default_nettype none

package thd_pkg;

    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int MAX_HEIGHT       = 2048;
    localparam int NUM_CH           = 4;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 2;
    localparam int ROW_W            = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 2'd2;

    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_BOX     = 1'b1;

endpackage

`default_nettype wire

@@ sv/texture_half_downsampler.sv @@
// Texture half downsampler: 2x2 mipmap reduction of a raster pixel stream.
// Uses thd_pkg and the assertion macros in texture_half_downsampler_assert.svh.
//
// Usage:
//   s_* carries source pixels in raster order, top row first; s_tdata holds
//   red, green, blue, alpha from the lowest bit up. m_* carries one reduced
//   pixel per complete 2x2 block; m_tlast marks the final pixel of the
//   reduced texture. An odd last column or row is consumed without output.
//   The cfg port sets source width, source height and filter mode (nearest
//   top-left sample or truncated box average); write it only while idle.
//   Throughput is one source pixel per cycle. The line store is a single
//   port RAM of MAX_WIDTH/2 entries, written on even rows and read once per
//   block on odd rows; the registered read stage and then the output register
//   raise m_tvalid after the accepting edge of the block's last pixel.
//   When m_tready is low, the output register and one read stage fill, then
//   s_tready drops until the output beat is taken.
//   Synchronous reset clears the position counters, the pipeline and the
//   registers to width 2, height 2, box mode. The line store is not cleared:
//   every entry is written on an even row before the odd row reads it.
`default_nettype none

module texture_half_downsampler
    import thd_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]                cfg_index,
    input  wire  [CFG_W-1:0]                    cfg_wdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // red_in, green_in, blue_in, alpha_in from the lowest bit up
    input  wire  [((NUM_CH*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // red_out, green_out, blue_out, alpha_out from the lowest bit up
    output logic [((NUM_CH*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                m_tlast
);

    `include "texture_half_downsampler_assert.svh"

    localparam int CB     = CHANNEL_BITS;
    localparam int DW     = ((NUM_CH*CB+7)/8)*8;
    localparam int XB     = $clog2(MAX_WIDTH);
    localparam int AW     = XB - 1;
    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int WB     = ($clog2(MAX_WIDTH+1) > CFG_W) ? $clog2(MAX_WIDTH+1) : CFG_W;
    localparam int LW     = CB + 1;

    typedef logic [NUM_CH-1:0][CB-1:0] pix_t;
    typedef logic [NUM_CH-1:0][LW-1:0] entry_t;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(2);
            height_reg <= CFG_W'(2);
            mode_reg   <= MODE_BOX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg  <= cfg_wdata;
                REG_SOURCE_HEIGHT: height_reg <= cfg_wdata;
                REG_FILTER_MODE:   mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [WB-1:0]    w_ext;
    logic [WB-1:0]    eff_w;
    logic [CFG_W-1:0] eff_h;

    always_comb begin
        w_ext = WB'(width_reg);
        if (w_ext > WB'(MAX_WIDTH)) begin
            eff_w = WB'(MAX_WIDTH);
        end else if (w_ext == '0) begin
            eff_w = WB'(1);
        end else begin
            eff_w = w_ext;
        end
        if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else if (height_reg == '0) begin
            eff_h = CFG_W'(1);
        end else begin
            eff_h = height_reg;
        end
    end

    // position and held even-column pixel
    logic [XB-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pix_t             held_reg;

    // read stage
    logic   p1_valid_reg;
    pix_t   p1_held_reg;
    pix_t   p1_px_reg;
    logic   p1_mode_reg;
    logic   p1_last_reg;

    // output register
    logic             m_tvalid_reg;
    logic [DW-1:0]    m_tdata_reg;
    logic             m_tlast_reg;

    logic             out_free;
    logic             p1_move;
    logic             s_acc;
    pix_t             px;
    logic [WB-1:0]    x_ext;
    logic [CFG_W-1:0] y_ext;
    logic             in_frame;
    logic             store_wr;
    logic             store_rd;
    logic             blk_last;
    logic             row_wrap;
    logic [AW-1:0]    slot;
    entry_t           wr_entry;
    entry_t           rd_entry;

    assign out_free = !m_tvalid_reg || m_tready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign px       = pix_t'(s_tdata[NUM_CH*CB-1:0]);

    always_comb begin
        x_ext    = WB'(col_reg);
        y_ext    = CFG_W'(row_reg);
        in_frame = (x_ext < {eff_w[WB-1:1], 1'b0}) && (y_ext < {eff_h[CFG_W-1:1], 1'b0});
        store_wr = s_acc && in_frame && col_reg[0] && !row_reg[0];
        store_rd = s_acc && in_frame && col_reg[0] && row_reg[0];
        slot     = col_reg[XB-1:1];
        blk_last = (x_ext[WB-1:1] == (eff_w[WB-1:1] - (WB-1)'(1)))
                && (y_ext[CFG_W-1:1] == (eff_h[CFG_W-1:1] - (CFG_W-1)'(1)));
        for (int c = 0; c < NUM_CH; c++) begin
            if (mode_reg == MODE_BOX) begin
                wr_entry[c] = LW'(held_reg[c]) + LW'(px[c]);
            end else begin
                wr_entry[c] = LW'(held_reg[c]);
            end
        end
        row_wrap = (x_ext + WB'(1)) >= eff_w;
        if (row_wrap) begin
            col_next = '0;
            row_next = ((y_ext + CFG_W'(1)) >= eff_h) ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + XB'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (s_acc && in_frame && !col_reg[0]) begin
            held_reg <= px;
        end
    end

    // line store: one entry per output column, read data registered
    entry_t store_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[slot] <= wr_entry;
        end
        if (store_rd) begin
            rd_entry <= store_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (store_rd) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_rd) begin
            p1_held_reg <= held_reg;
            p1_px_reg   <= px;
            p1_mode_reg <= mode_reg;
            p1_last_reg <= blk_last;
        end
    end

    // finish the block: box mode adds the odd-row pair to the stored value, nearest mode passes it on
    pix_t          res_px;
    logic [CB+1:0] box_sum;

    always_comb begin
        res_px  = '0;
        box_sum = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            box_sum = (CB+2)'(rd_entry[c]) + (CB+2)'(p1_held_reg[c]) + (CB+2)'(p1_px_reg[c]);
            if (p1_mode_reg == MODE_BOX) begin
                res_px[c] = box_sum[CB+1:2];
            end else begin
                res_px[c] = rd_entry[c][CB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (p1_move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_tdata_reg <= DW'(res_px);
            m_tlast_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `THD_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn,
        p1_valid_reg && m_tvalid_reg && !m_tready, !s_tready)
    `THD_ASSERT_NXT(a_read_fills_stage, aclk, aresetn, store_rd, p1_valid_reg)
    `THD_ASSERT_NXT(a_stage_moves_out, aclk, aresetn, p1_move, m_tvalid_reg)
    `THD_ASSERT_NXT(a_row_wrap_clears_col, aclk, aresetn, s_acc && row_wrap, col_reg == '0)

endmodule

`default_nettype wire
